>>> src/tsp_pkg.sv
// Shared types and constants for the timed slot pool.
package tsp_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_SWEEP = 1'b1;

   localparam int unsigned FIELD_SLOT_BITS  = 9;
   localparam int unsigned FIELD_COUNT_BITS = 10;
   localparam int unsigned PERIOD_BITS      = 10;
   localparam int unsigned LIFE_BITS        = 16;
   localparam int unsigned TIME_FIELD_BITS  = 32;
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 10'd100;

   // Datapath commands, one per controller step.
   typedef struct packed {
      logic clear_step;   // write one entry of the link clearing pass
      logic latch_req;    // capture the request
      logic rd_free;      // read next_link of free head
      logic alloc_pop;    // pop free list with read data
      logic rd_oldest;    // read links of the oldest active slot
      logic evict_unlink; // unlink oldest using read links
      logic alloc_link;   // record slot and push at newest end
      logic sw_start;     // start the walk at the newest slot
      logic sw_read;      // read links and timing of the walk slot
      logic sw_mult;      // register the lifetime product
      logic sw_eval;      // decide and free
      logic rsp_load;     // load the response register
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic op_sweep;
      logic free_valid;
      logic oldest_valid;
      logic walk_valid;
      logic walk_last;
   } stat_type;

endpackage

>>> src/tsp_ctrl.sv
// Controller state machine for the timed slot pool.
module tsp_ctrl
   import tsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     rsp_busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_DEC    = 4'd2;
   localparam logic [3:0] ST_APOP   = 4'd3;
   localparam logic [3:0] ST_EVICT  = 4'd4;
   localparam logic [3:0] ST_LINK   = 4'd5;
   localparam logic [3:0] ST_WREAD  = 4'd6;
   localparam logic [3:0] ST_WMULT  = 4'd7;
   localparam logic [3:0] ST_WEVAL  = 4'd8;
   localparam logic [3:0] ST_RESP   = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            if (stat.op_sweep) begin
               cmd.sw_start = 1'b1;
               state_in = ST_WREAD;
            end else if (stat.free_valid) begin
               cmd.rd_free = 1'b1;
               state_in = ST_APOP;
            end else if (stat.oldest_valid) begin
               cmd.rd_oldest = 1'b1;
               state_in = ST_EVICT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_APOP: begin
            cmd.alloc_pop = 1'b1;
            state_in = ST_LINK;
         end
         ST_EVICT: begin
            cmd.evict_unlink = 1'b1;
            state_in = ST_LINK;
         end
         ST_LINK: begin
            cmd.alloc_link = 1'b1;
            state_in = ST_RESP;
         end
         ST_WREAD: begin
            if (stat.walk_valid) begin
               cmd.sw_read = 1'b1;
               state_in = ST_WMULT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_WMULT: begin
            cmd.sw_mult = 1'b1;
            state_in = ST_WEVAL;
         end
         ST_WEVAL: begin
            cmd.sw_eval = 1'b1;
            state_in = stat.walk_last ? ST_RESP : ST_WREAD;
         end
         ST_RESP: begin
            if (!rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !cmd.alloc_link && !cmd.sw_eval) else $error("busy while ready");
   a_one_path: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_free && cmd.rd_oldest)) else $error("two allocation paths");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !rsp_busy) else $error("response overwritten");

endmodule

>>> src/tsp_dp.sv
// Datapath of the timed slot pool: link memories, timing memories, pointers.
module tsp_dp
   import tsp_pkg::*;
#(
   parameter int unsigned SLOTS     = 512,
   parameter int unsigned TIME_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output stat_type                    stat,
   input  logic                        csr_write_enable,
   input  logic [PERIOD_BITS-1:0]      csr_write_data,
   input  logic                        req_opcode,
   input  logic [TIME_FIELD_BITS-1:0]  req_start_time,
   input  logic [LIFE_BITS-1:0]        req_lifetime_frames,
   input  logic [TIME_FIELD_BITS-1:0]  req_now_time,
   output logic [FIELD_SLOT_BITS-1:0]  res_slot,
   output logic                        res_evicted,
   output logic [FIELD_COUNT_BITS-1:0] res_freed
);

   localparam int unsigned IW = $clog2(SLOTS);
   localparam int unsigned PW = $clog2(SLOTS + 1);
   localparam logic [PW-1:0] NIL = PW'(SLOTS);
   localparam int unsigned PRODW = PERIOD_BITS + LIFE_BITS;

   logic [PW-1:0] next_mem [SLOTS];
   logic [PW-1:0] prev_mem [SLOTS];
   logic signed [TIME_BITS-1:0] start_mem [SLOTS];
   logic [LIFE_BITS-1:0] life_mem [SLOTS];

   logic [PERIOD_BITS-1:0] period_ff;
   logic [PW-1:0] free_head_ff, newest_ff, oldest_ff;
   logic [PW-1:0] clr_ff;
   logic op_ff;
   logic signed [TIME_BITS-1:0] start_ff, now_ff;
   logic [LIFE_BITS-1:0] life_ff;
   logic [IW-1:0] slot_ff;
   logic evicted_ff;
   logic [PW-1:0] count_ff;
   logic [PW-1:0] walk_ff;
   logic [PW-1:0] rd_next_ff, rd_prev_ff;
   logic signed [TIME_BITS-1:0] rd_start_ff;
   logic [LIFE_BITS-1:0] rd_life_ff;
   logic [PRODW-1:0] lim_ff;
   logic signed [TIME_BITS:0] diff_ff;
   logic short_ff;

   function automatic logic ok(input logic [PW-1:0] s);
      return s < NIL;
   endfunction

   logic [IW-1:0] walk_idx, old_idx;
   assign walk_idx = walk_ff[IW-1:0];
   assign old_idx  = oldest_ff[IW-1:0];

   logic dead;
   assign dead = short_ff || (diff_ff >= $signed({1'b0, lim_ff}));

   assign stat.clear_done   = (clr_ff == NIL - PW'(1));
   assign stat.op_sweep     = (op_ff == OP_SWEEP);
   assign stat.free_valid   = ok(free_head_ff);
   assign stat.oldest_valid = ok(oldest_ff);
   assign stat.walk_valid   = ok(walk_ff);
   assign stat.walk_last    = !ok(rd_next_ff);

   // Unlink helper pointers, used for eviction and freeing.
   logic [PW-1:0] u_prev, u_next;
   assign u_prev = rd_prev_ff;
   assign u_next = rd_next_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RESET;
         free_head_ff <= '0;
         newest_ff    <= NIL;
         oldest_ff    <= NIL;
         clr_ff       <= '0;
      end else begin
         if (csr_write_enable) period_ff <= csr_write_data;
         if (cmd.clear_step) begin
            next_mem[clr_ff[IW-1:0]] <= clr_ff + PW'(1);
            prev_mem[clr_ff[IW-1:0]] <= '0;
            clr_ff <= clr_ff + PW'(1);
         end
         if (cmd.latch_req) begin
            op_ff      <= req_opcode;
            start_ff   <= req_start_time[TIME_BITS-1:0];
            life_ff    <= req_lifetime_frames;
            now_ff     <= req_now_time[TIME_BITS-1:0];
            slot_ff    <= '0;
            evicted_ff <= 1'b0;
            count_ff   <= '0;
         end
         if (cmd.rd_free) begin
            rd_next_ff <= next_mem[free_head_ff[IW-1:0]];
            slot_ff    <= free_head_ff[IW-1:0];
         end
         if (cmd.alloc_pop) free_head_ff <= rd_next_ff;
         if (cmd.rd_oldest) begin
            rd_next_ff <= next_mem[old_idx];
            rd_prev_ff <= prev_mem[old_idx];
            slot_ff    <= old_idx;
            evicted_ff <= 1'b1;
         end
         if (cmd.evict_unlink) begin
            // oldest has no successor; its predecessor becomes oldest
            if (ok(u_prev)) next_mem[u_prev[IW-1:0]] <= NIL;
            else            newest_ff <= NIL;
            oldest_ff <= u_prev;
         end
         if (cmd.alloc_link) begin
            start_mem[slot_ff] <= start_ff;
            life_mem[slot_ff]  <= life_ff;
            prev_mem[slot_ff]  <= NIL;
            next_mem[slot_ff]  <= newest_ff;
            if (ok(newest_ff)) prev_mem[newest_ff[IW-1:0]] <= PW'(slot_ff);
            else               oldest_ff <= PW'(slot_ff);
            newest_ff <= PW'(slot_ff);
         end
         if (cmd.sw_start) walk_ff <= newest_ff;
         if (cmd.sw_read) begin
            rd_next_ff  <= next_mem[walk_idx];
            rd_prev_ff  <= prev_mem[walk_idx];
            rd_start_ff <= start_mem[walk_idx];
            rd_life_ff  <= life_mem[walk_idx];
         end
         if (cmd.sw_mult) begin
            short_ff <= (rd_life_ff <= LIFE_BITS'(1));
            lim_ff   <= period_ff * (rd_life_ff - LIFE_BITS'(1));
            diff_ff  <= (TIME_BITS+1)'(now_ff) - (TIME_BITS+1)'(rd_start_ff);
         end
         if (cmd.sw_eval) begin
            if (dead) begin
               // Successor was already read, so overwriting next_mem with the free head is safe
               if (ok(u_prev)) next_mem[u_prev[IW-1:0]] <= u_next;
               else            newest_ff <= u_next;
               if (ok(u_next)) prev_mem[u_next[IW-1:0]] <= u_prev;
               else            oldest_ff <= u_prev;
               next_mem[walk_idx] <= free_head_ff;
               free_head_ff <= walk_ff;
               count_ff <= count_ff + PW'(1);
            end
            walk_ff <= rd_next_ff;
         end
      end
   end

   assign res_slot    = FIELD_SLOT_BITS'(slot_ff);
   assign res_evicted = evicted_ff;
   assign res_freed   = FIELD_COUNT_BITS'(count_ff);

endmodule

>>> src/timed_slot_pool_evict_oldest.sv
// Top level of the timed slot pool with oldest-first eviction.
// A pool of SLOTS slots: allocation pops a LIFO free list, or evicts the oldest
// active slot when none is free, and pushes the slot at the newest end of the
// active list. A sweep walks the active list newest to oldest and frees each
// slot whose lifetime is at most one frame or whose age (now minus start, in
// ms) reaches frame_period_ms times (lifetime minus one). After reset a
// clearing pass writes one link entry per slot and relinks the free list
// before the first request is taken. An allocation passes the decode, pop or
// evict, link and response states; a sweep passes decode, then the read,
// multiply and decide steps per active slot, then the response state.
// The response waits in its own register, so a new request is accepted while
// the previous response is still held.
module timed_slot_pool_evict_oldest
   import tsp_pkg::*;
#(
   parameter int unsigned SLOTS     = 512,
   parameter int unsigned TIME_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [PERIOD_BITS-1:0]      csr_write_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [TIME_FIELD_BITS-1:0]  req_start_time,
   input  logic [LIFE_BITS-1:0]        req_lifetime_frames,
   input  logic [TIME_FIELD_BITS-1:0]  req_now_time,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [FIELD_SLOT_BITS-1:0]  rsp_slot_index,
   output logic                        rsp_evicted,
   output logic [FIELD_COUNT_BITS-1:0] rsp_freed_count
);

   cmd_type  cmd;
   stat_type stat;
   logic [FIELD_SLOT_BITS-1:0]  res_slot;
   logic                        res_evicted;
   logic [FIELD_COUNT_BITS-1:0] res_freed;
   logic rsp_valid_ff;
   logic [FIELD_SLOT_BITS-1:0]  slot_ff;
   logic                        evicted_ff;
   logic [FIELD_COUNT_BITS-1:0] freed_ff;

   tsp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready,
      .rsp_busy (rsp_valid_ff && !rsp_ready),
      .stat, .cmd
   );

   tsp_dp #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
      .clock, .reset, .cmd, .stat, .csr_write_enable, .csr_write_data,
      .req_opcode, .req_start_time, .req_lifetime_frames, .req_now_time,
      .res_slot, .res_evicted, .res_freed
   );

   // Hold the response until taken; load a new one when the register frees.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         slot_ff    <= res_slot;
         evicted_ff <= res_evicted;
         freed_ff   <= res_freed;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot_index  = slot_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_freed_count = freed_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_index))
      else $error("response dropped");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_evicted && rsp_valid |-> rsp_freed_count == '0)
      else $error("evict on sweep");
   a_alloc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_freed_count != '0 |-> !rsp_evicted && rsp_slot_index == '0)
      else $error("mixed response");

endmodule

>>> tb/timed_slot_pool_evict_oldest_tb.sv
// Self-checking testbench for the timed slot pool: directed table, fill and period tests, then random traffic.
module timed_slot_pool_evict_oldest_tb
   import tsp_pkg::*;
();

   localparam int unsigned NSLOT = 512;
   localparam int unsigned NIL   = NSLOT;
   localparam int unsigned N_RANDOM = 360;
   localparam longint CYCLE_LIMIT = 64'd20000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [PERIOD_BITS-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = OP_ALLOC;
   logic [TIME_FIELD_BITS-1:0] req_start_time = '0;
   logic [LIFE_BITS-1:0] req_lifetime_frames = '0;
   logic [TIME_FIELD_BITS-1:0] req_now_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [FIELD_SLOT_BITS-1:0] rsp_slot_index;
   logic rsp_evicted;
   logic [FIELD_COUNT_BITS-1:0] rsp_freed_count;

   timed_slot_pool_evict_oldest u_dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_start_time(req_start_time), .req_lifetime_frames(req_lifetime_frames),
      .req_now_time(req_now_time),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_slot_index(rsp_slot_index),
      .rsp_evicted(rsp_evicted), .rsp_freed_count(rsp_freed_count)
   );

   always #5 clock = ~clock;

   typedef struct packed {
      logic [FIELD_SLOT_BITS-1:0]  slot;
      logic                        evicted;
      logic [FIELD_COUNT_BITS-1:0] freed;
   } pool_answer_type;

   typedef struct {
      logic                       op;
      logic [TIME_FIELD_BITS-1:0] start_t;
      logic [LIFE_BITS-1:0]       life;
      logic [TIME_FIELD_BITS-1:0] now_t;
      bit                         typed;   // expected answer written into the row
      pool_answer_type            answer;
   } pool_row_type;

   // Shadow copy of the pool
   int unsigned sh_next [NSLOT];
   int unsigned sh_prev [NSLOT];
   longint      sh_start[NSLOT];
   int unsigned sh_life [NSLOT];
   int unsigned sh_free_head, sh_newest, sh_oldest;
   int unsigned sh_period;

   pool_answer_type pending_answers[$];
   int  mismatches = 0;
   longint cycle_count = 0;
   int  send_idle_pct = 0;   // sender gap probability, percent
   int  recv_stall_pct = 0;  // receiver stall probability, percent
   bit  hold_off = 1'b0;     // long receiver hold-off in progress

   function automatic void shadow_reset();
      for (int i = 0; i < NSLOT; i++) begin
         sh_next[i] = i + 1;
         sh_prev[i] = 0;
         sh_start[i] = 0;
         sh_life[i] = 0;
      end
      sh_free_head = 0;
      sh_newest = NIL;
      sh_oldest = NIL;
      sh_period = PERIOD_RESET;
   endfunction

   function automatic void shadow_unlink(int unsigned s);
      int unsigned p, n;
      p = sh_prev[s];
      n = sh_next[s];
      if (p < NSLOT) sh_next[p] = n; else sh_newest = n;
      if (n < NSLOT) sh_prev[n] = p; else sh_oldest = p;
   endfunction

   // Apply one request to the shadow pool and return its answer
   function automatic pool_answer_type pool_predict(logic op, logic [31:0] st,
                                                    logic [15:0] lf, logic [31:0] nw);
      pool_answer_type a;
      int unsigned s, nx, cnt;
      longint now_v, lim;
      bit dead;
      a = '0;
      if (op == OP_ALLOC) begin
         if (sh_free_head < NSLOT) begin
            s = sh_free_head;
            sh_free_head = sh_next[s];
         end else if (sh_oldest < NSLOT) begin
            s = sh_oldest;
            shadow_unlink(s);
            a.evicted = 1'b1;
         end else begin
            return '0;
         end
         sh_start[s] = longint'($signed(st));
         sh_life[s] = lf;
         sh_prev[s] = NIL;
         sh_next[s] = sh_newest;
         if (sh_newest < NSLOT) sh_prev[sh_newest] = s; else sh_oldest = s;
         sh_newest = s;
         a.slot = s[FIELD_SLOT_BITS-1:0];
      end else begin
         now_v = longint'($signed(nw));
         s = sh_newest;
         cnt = 0;
         for (int g = 0; g < NSLOT && s < NSLOT; g++) begin
            nx = sh_next[s];
            if (sh_life[s] <= 1) dead = 1'b1;
            else begin
               lim = longint'(sh_period) * longint'(sh_life[s] - 1);
               dead = (now_v - sh_start[s]) >= lim;
            end
            if (dead) begin
               shadow_unlink(s);
               sh_next[s] = sh_free_head;
               sh_free_head = s;
               cnt++;
            end
            s = nx;
         end
         a.freed = cnt[FIELD_COUNT_BITS-1:0];
      end
      return a;
   endfunction

   // Cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timed_slot_pool_evict_oldest_tb NOT OK");
         $finish;
      end
   end

   // Check each response against the oldest expectation
   always @(posedge clock) begin
      pool_answer_type exp_a;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response slot=%0d", rsp_slot_index);
         end else begin
            exp_a = pending_answers.pop_front();
            if (rsp_slot_index !== exp_a.slot || rsp_evicted !== exp_a.evicted ||
                rsp_freed_count !== exp_a.freed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp slot=%0d ev=%0d freed=%0d got slot=%0d ev=%0d freed=%0d",
                           exp_a.slot, exp_a.evicted, exp_a.freed,
                           rsp_slot_index, rsp_evicted, rsp_freed_count);
            end
         end
      end
   end

   // Receiver: random stalls, or a long hold-off while the sender keeps offering
   always @(negedge clock) begin
      if (hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic hold_receiver(int cycles);
      hold_off = 1'b1;
      repeat (cycles) @(negedge clock);
      hold_off = 1'b0;
   endtask

   // Offer one request; hold valid and payload until accepted
   task automatic send_request(pool_row_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= r.op;
      req_start_time <= r.start_t;
      req_lifetime_frames <= r.life;
      req_now_time <= r.now_t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // accepted at this edge: predict, or take the typed answer
      begin
         pool_answer_type a;
         a = pool_predict(r.op, r.start_t, r.life, r.now_t);
         pending_answers.push_back(r.typed ? r.answer : a);
      end
      @(negedge clock);
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (3 * NSLOT + 20) @(negedge clock);
   endtask

   task automatic write_period(logic [PERIOD_BITS-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sh_period = v;
   endtask

   function automatic pool_row_type make_row(logic op, logic [31:0] st, logic [15:0] lf,
                                             logic [31:0] nw);
      pool_row_type r;
      r.op = op; r.start_t = st; r.life = lf; r.now_t = nw;
      r.typed = 1'b0; r.answer = '0;
      return r;
   endfunction

   function automatic pool_row_type typed_row(logic op, logic [31:0] st, logic [15:0] lf,
                                              logic [31:0] nw, int slot, bit ev, int fr);
      pool_row_type r;
      r = make_row(op, st, lf, nw);
      r.typed = 1'b1;
      r.answer.slot = FIELD_SLOT_BITS'(slot);
      r.answer.evicted = ev;
      r.answer.freed = FIELD_COUNT_BITS'(fr);
      return r;
   endfunction

   // Random request: allocations mostly with modest times, sweeps with nearby now
   function automatic pool_row_type random_row(longint base);
      logic [31:0] st, nw;
      logic [15:0] lf;
      int k;
      k = $urandom_range(99);
      st = (k < 8) ? $urandom() : 32'(base + $urandom_range(2000) - 1000);
      nw = (k < 8) ? $urandom() : 32'(base + $urandom_range(40000));
      case ($urandom_range(5))
         0: lf = 16'($urandom());
         1: lf = 16'($urandom_range(1));
         default: lf = 16'($urandom_range(300));
      endcase
      return make_row(($urandom_range(99) < 75) ? OP_ALLOC : OP_SWEEP, st, lf, nw);
   endfunction

   pool_row_type directed_rows[$];

   initial begin
      longint base;
      shadow_reset();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: fresh pool pops slot 0 upward; empty sweep frees nothing
      directed_rows.push_back(typed_row(OP_SWEEP, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(typed_row(OP_ALLOC, 32'h8000_0000, 16'hFFFF, 0, 0, 0, 0));
      directed_rows.push_back(typed_row(OP_ALLOC, 32'h7FFF_FFFF, 16'h0000, 0, 1, 0, 0));
      directed_rows.push_back(typed_row(OP_ALLOC, 0, 16'h0001, 0, 2, 0, 0));
      directed_rows.push_back(typed_row(OP_ALLOC, 32'hFFFF_FFFF, 16'h0002, 0, 3, 0, 0));
      // lifetimes 0 and 1 always expire; extreme times without wrap
      directed_rows.push_back(make_row(OP_SWEEP, 0, 0, 32'h8000_0000));
      directed_rows.push_back(make_row(OP_SWEEP, 0, 0, 32'h7FFF_FFFF));
      directed_rows.push_back(make_row(OP_ALLOC, 100, 16'd2, 0));
      directed_rows.push_back(make_row(OP_SWEEP, 0, 0, 199));
      directed_rows.push_back(make_row(OP_SWEEP, 0, 0, 200));
      foreach (directed_rows[i]) send_request(directed_rows[i]);
      drain_and_settle();

      // Fill the pool and overrun it to force oldest-first eviction
      for (int i = 0; i < NSLOT + 8; i++)
         send_request(make_row(OP_ALLOC, 32'(i), 16'hFFFF, 0));
      send_request(make_row(OP_SWEEP, 0, 0, 32'h7FFF_FFFF));
      drain_and_settle();

      // Period zero, then the top extreme
      write_period('0);
      send_request(make_row(OP_ALLOC, 10, 16'd500, 0));
      send_request(make_row(OP_ALLOC, 10, 16'd500, 0));
      send_request(make_row(OP_SWEEP, 0, 0, 9));
      send_request(make_row(OP_SWEEP, 0, 0, 10));
      drain_and_settle();
      write_period(10'd1023);

      // Random phases: none, sender idle, receiver stall, both, receiver hold-off, both
      base = 0;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
            3: begin send_idle_pct = 18; recv_stall_pct = 18; end
            4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         if (ph == 4) fork hold_receiver(400); join_none
         for (int i = 0; i < N_RANDOM / 6; i++) begin
            send_request(random_row(base));
            base += $urandom_range(300);
         end
         drain_and_settle();
         write_period((ph == 2) ? 10'd1 : 10'($urandom_range(1, 1000)));
      end

      if (mismatches == 0) $display("timed_slot_pool_evict_oldest_tb OK");
      else $display("timed_slot_pool_evict_oldest_tb NOT OK");
      $finish;
   end

endmodule

>>> files.f
src/tsp_pkg.sv
src/tsp_ctrl.sv
src/tsp_dp.sv
src/timed_slot_pool_evict_oldest.sv
tb/timed_slot_pool_evict_oldest_tb.sv
